@@ rtl/bzd_pkg.sv @@
// Shared types and constants for the binary to zoned decimal unit.
// Depends on nothing. Imported by the controller, the datapath and the top level.
`default_nettype none

package bzd_pkg;

    localparam int BIN_W       = 64;
    localparam int BCD_DIGITS  = 19;
    localparam int BCD_W       = BCD_DIGITS * 4;
    localparam int STEP_W      = 6;
    localparam int DIGITS_DEF  = 19;
    localparam int CHAR_W      = 6;
    localparam int STATUS_W    = 2;

    localparam logic [CHAR_W-1:0]   ASCII_ZERO = 6'd48;

    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEG = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BIG = 2'd2;

    typedef struct packed {
        logic                load;
        logic                step;
        logic                start_emit;
        logic                emit_digit;
        logic                emit_error;
        logic [STATUS_W-1:0] err_code;
    } bzd_cmd_t;

    typedef struct packed {
        logic neg;
        logic conv_done;
        logic too_big;
        logic last_digit;
        logic out_free;
    } bzd_stat_t;

endpackage

`default_nettype wire

@@ rtl/bzd_ctrl.sv @@
// Controller state machine of the binary to zoned decimal unit.
// Depends on bzd_pkg; drives the datapath through command and status structs.
`default_nettype none

module bzd_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  bzd_pkg::bzd_stat_t  stat,
    output bzd_pkg::bzd_cmd_t   cmd
);
    import bzd_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CONV    = 3'd1;
    localparam logic [2:0] S_CHECK   = 3'd2;
    localparam logic [2:0] S_EMIT    = 3'd3;
    localparam logic [2:0] S_ERR_NEG = 3'd4;
    localparam logic [2:0] S_ERR_BIG = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.err_code   = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = stat.neg ? S_ERR_NEG : S_CONV;
                end
            end
            S_CONV: begin
                cmd.step = 1'b1;
                if (stat.conv_done) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.too_big) begin
                    state_next = S_ERR_BIG;
                end else begin
                    cmd.start_emit = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (stat.last_digit) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERR_NEG: begin
                cmd.err_code = ST_NEG;
                if (stat.out_free) begin
                    cmd.emit_error = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_ERR_BIG: begin
                cmd.err_code = ST_BIG;
                if (stat.out_free) begin
                    cmd.emit_error = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/bzd_datapath.sv @@
// Datapath of the binary to zoned decimal unit: shift-add-3 converter,
// digit counter and output register. Depends on bzd_pkg.
`default_nettype none

module bzd_datapath #(
    parameter int DIGITS = bzd_pkg::DIGITS_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire  [bzd_pkg::BIN_W-1:0]     s_bin_value,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [bzd_pkg::CHAR_W-1:0]    m_digit_char,
    output logic                          m_last_char,
    output logic [bzd_pkg::STATUS_W-1:0]  m_status,
    input  bzd_pkg::bzd_cmd_t             cmd,
    output bzd_pkg::bzd_stat_t            stat
);
    import bzd_pkg::*;

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(DIGITS - 1);

    logic [BIN_W-1:0]    bin_reg;
    logic [BIN_W-1:0]    bin_next;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BCD_W-1:0]    bcd_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [CHAR_W-1:0]   char_reg;
    logic [CHAR_W-1:0]   char_next;
    logic                last_reg;
    logic                last_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [3:0]          sel_digit;
    logic                big;

    // Each digit of five or more gets three added before the shift.
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb begin
        sel_digit = 4'd0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (32'(idx_reg) == i) begin
                sel_digit = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb begin
        big = 1'b0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (i >= DIGITS && bcd_reg[i*4 +: 4] != 4'd0) begin
                big = 1'b1;
            end
        end
    end

    always_comb begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        status_next  = status_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.load) begin
            bin_next  = s_bin_value;
            bcd_next  = '0;
            step_next = '0;
        end
        if (cmd.step) begin
            bcd_next  = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next  = {bin_reg[BIN_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
        end
        if (cmd.start_emit) begin
            idx_next = IDX_TOP;
        end
        if (cmd.emit_digit) begin
            m_valid_next = 1'b1;
            char_next    = ASCII_ZERO + CHAR_W'(sel_digit);
            last_next    = (idx_reg == '0);
            status_next  = ST_OK;
            idx_next     = idx_reg - IDX_W'(1);
        end
        if (cmd.emit_error) begin
            m_valid_next = 1'b1;
            char_next    = '0;
            last_next    = 1'b1;
            status_next  = cmd.err_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            step_reg    <= step_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign stat.neg        = s_bin_value[BIN_W-1];
    assign stat.conv_done  = (step_reg == {STEP_W{1'b1}});
    assign stat.too_big    = big;
    assign stat.last_digit = (idx_reg == '0);
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_digit_char = char_reg;
    assign m_last_char  = last_reg;
    assign m_status     = status_reg;

endmodule

`default_nettype wire

@@ rtl/binary_to_zoned_decimal_unit.sv @@
// Top level of the binary to zoned decimal unit.
// Depends on bzd_pkg, bzd_ctrl and bzd_datapath.
//
// The unit takes one signed 64-bit value per transfer and returns DIGITS
// ASCII digit transfers, most significant first and padded with '0', the
// last one marked by m_last_char. A negative value, or one with more
// decimal digits than DIGITS, gives a single transfer with digit 0, the
// last mark set and an error status. An item passes through a load, the
// shift-add-3 converter over all 64 input bits (one input bit per cycle),
// one range check, then one character per cycle from the output register
// while the output side does not stall. A negative value skips the
// converter. Items are handled one at a time.
`default_nettype none

module binary_to_zoned_decimal_unit #(
    parameter int DIGITS = bzd_pkg::DIGITS_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [bzd_pkg::BIN_W-1:0]     s_bin_value,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [bzd_pkg::CHAR_W-1:0]    m_digit_char,
    output logic                          m_last_char,
    output logic [bzd_pkg::STATUS_W-1:0]  m_status
);
    import bzd_pkg::*;

    bzd_cmd_t  cmd;
    bzd_stat_t stat;

    bzd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bzd_datapath #(
        .DIGITS (DIGITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_bin_value  (s_bin_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_char  (m_last_char),
        .m_status     (m_status),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

`default_nettype wire

@@ sim/tb_binary_to_zoned_decimal_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for binary_to_zoned_decimal_unit: sends signed 64-bit values and
// checks every ASCII digit transfer against a predictor kept in this file.
// Depends on bzd_pkg and the RTL of the unit; reads no files.

module tb_binary_to_zoned_decimal_unit;

    import bzd_pkg::*;

    localparam int DIGITS     = DIGITS_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_N   = 142;
    localparam logic [BIN_W-1:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [BIN_W-1:0] MIN_NEG = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [CHAR_W-1:0]   digit;
        logic                last;
        logic [STATUS_W-1:0] status;
    } zoned_char_t;

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_LONG_STALL} rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BIN_W-1:0]      s_bin_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CHAR_W-1:0]     m_digit_char;
    logic                  m_last_char;
    logic [STATUS_W-1:0]   m_status;

    zoned_char_t pending_chars[$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    rx_mode_t    rx_mode = RX_FREE;
    int          rx_mode_left = 0;
    int          rx_hold = 0;

    always #2 aclk = ~aclk;

    binary_to_zoned_decimal_unit #(
        .DIGITS(DIGITS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_bin_value(s_bin_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_digit_char(m_digit_char),
        .m_last_char(m_last_char),
        .m_status(m_status)
    );

    function automatic logic [BIN_W-1:0] pow_ten(input int n);
        logic [BIN_W-1:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) p = p * 64'd10;
        return p;
    endfunction

    function automatic logic [BIN_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic predict_zoned_field(input logic [BIN_W-1:0] value);
        logic [BIN_W-1:0]  v;
        logic [CHAR_W-1:0] field [DIGITS];
        int                len;
        bit                too_big;
        if (value[BIN_W-1]) begin
            pending_chars.push_back('{digit: '0, last: 1'b1, status: ST_NEG});
            return;
        end
        for (int k = 0; k < DIGITS; k++) field[k] = ASCII_ZERO;
        v = value;
        len = 0;
        too_big = 1'b0;
        while (v != 0) begin
            if (len >= DIGITS) begin
                too_big = 1'b1;
                break;
            end
            field[len] = ASCII_ZERO + CHAR_W'(v % 64'd10);
            len++;
            v = v / 64'd10;
        end
        if (too_big) begin
            pending_chars.push_back('{digit: '0, last: 1'b1, status: ST_BIG});
        end else begin
            for (int k = 0; k < DIGITS; k++) begin
                pending_chars.push_back('{digit: field[DIGITS-1-k],
                                         last: (k == DIGITS - 1),
                                         status: ST_OK});
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40) begin
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // The sender keeps valid high across a burst and only drops it for a gap.
    task automatic send_binary(input logic [BIN_W-1:0] value);
        int gap;
        s_valid <= 1'b1;
        s_bin_value <= value;
        do @(posedge aclk); while (!s_ready);
        predict_zoned_field(value);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                       : $urandom_range(0, 4);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    task automatic test_zero_and_small();
        send_binary(64'd0);
        send_binary(64'd1);
        send_binary(64'd9);
        send_binary(64'd10);
        send_binary(64'd12345);
    endtask

    task automatic test_extremes();
        send_binary(MAX_POS);
        send_binary(pow_ten(18));
        send_binary(pow_ten(18) - 64'd1);
        send_binary(64'h4000_0000_0000_0000);
        send_binary(64'h5555_5555_5555_5555);
        send_binary(64'h2AAA_AAAA_AAAA_AAAA);
    endtask

    task automatic test_negative();
        send_binary(64'hFFFF_FFFF_FFFF_FFFF);
        send_binary(MIN_NEG);
        send_binary(64'hAAAA_AAAA_AAAA_AAAA);
        send_binary(rand_word() | MIN_NEG);
    endtask

    task automatic test_width_limit();
        logic [BIN_W-1:0] lim;
        lim = (DIGITS < 19) ? pow_ten(DIGITS) : MAX_POS;
        send_binary(lim - 64'd1);
        send_binary(lim);
        send_binary(lim + 64'd1);
        wait_drained();
    endtask

    task automatic test_random();
        logic [BIN_W-1:0] value;
        logic [BIN_W-1:0] lo;
        logic [BIN_W-1:0] hi;
        int               n;
        int               kind;
        for (int i = 0; i < RANDOM_N; i++) begin
            kind = $urandom_range(0, 19);
            n = $urandom_range(1, 19);
            if (kind < 8) begin
                value = rand_word();
            end else if (kind < 17) begin
                lo = (n == 1) ? 64'd0 : pow_ten(n - 1);
                hi = (n == 19) ? MAX_POS : pow_ten(n) - 64'd1;
                value = lo + rand_word() % (hi - lo + 64'd1);
            end else begin
                n = (n == 19) ? 18 : n;
                value = pow_ten(n) + 64'($signed($urandom_range(0, 2)) - 1);
            end
            send_binary(value);
            if (i % 50 == 49) wait_drained();
        end
    endtask

    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(50, 400);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_FREE: begin
                m_ready <= 1'b1;
            end
            RX_RANDOM: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (rx_hold > 0) begin
                    rx_hold <= rx_hold - 1;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold <= $urandom_range(5, 60);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        zoned_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected transfer, digit", m_digit_char, -1);
            end else begin
                want = pending_chars.pop_front();
                if (m_digit_char !== want.digit) report_mismatch("digit", m_digit_char, want.digit);
                if (m_last_char !== want.last) report_mismatch("last", m_last_char, want.last);
                if (m_status !== want.status) report_mismatch("status", m_status, want.status);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_zero_and_small();
        test_extremes();
        test_negative();
        test_width_limit();
        test_random();
        wait_drained();
        repeat (DIGITS + 80) @(posedge aclk);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/bzd_pkg.sv
rtl/bzd_ctrl.sv
rtl/bzd_datapath.sv
rtl/binary_to_zoned_decimal_unit.sv
sim/tb_binary_to_zoned_decimal_unit.sv
